### design/nhpm_pkg.sv
// Shared types and constants for the next-hop prefix match block.
package nhpm_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);
  localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(ROUTE_ENTRIES);

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] entry_network;
    logic [31:0] entry_gateway;
    logic [31:0] entry_mask;
    logic [31:0] lookup_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_hop;
    logic        status;
  } out_item_t;

  // Token that walks the cell chain.
  // Append: cnt = target slot, a/b/c = network/gateway/mask.
  // Lookup: cnt = valid entries at entry, a = address, b/c = best gateway/mask.
  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic             status;
    logic [CNT_W-1:0] cnt;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [31:0]      c;
  } tok_t;

endpackage

### design/next_hop_prefix_match_top.sv
// Top level of the next-hop prefix match block: entry logic, cell chain, output register.
//
// Usage: items arrive on in_valid / in_stall / in_data; each gives exactly one
// result on out_valid / out_stall / out_data. kind selects clear, append or
// lookup. Entry i of the route table lives in cell i of a chain of
// ROUTE_ENTRIES cells; unless stalled, every item walks the chain one cell per cycle, so a
// lookup compares against each entry as it passes and appends write their
// slot when they reach it. Items stay in order end to end.
// Path: the accepting edge loads cell 0, the item then moves on through each
// cell's token register in turn, and from the last cell it is loaded into
// the output register.
// Throughput: one item per cycle unless stalled; an item may enter whenever in_stall is low.
// Stall: when out_stall holds a result, tokens pile up into empty cells and
// in_stall rises once cell 0 is occupied and cannot advance.
// Reset: the entry count clears to zero and the chain empties; table contents
// are not cleared, an entry is only compared once it has been appended.
module next_hop_prefix_match_top import nhpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             in_acc;
  tok_t             tok_entry;
  tok_t             tok_c [ROUTE_ENTRIES+1];
  logic             rdy   [ROUTE_ENTRIES+1];
  logic             out_valid_r;
  out_item_t        out_data_r;
  out_item_t        out_data_nxt;
  tok_t             tok_last;

  assign in_stall = !rdy[0];
  assign in_acc   = in_valid && rdy[0];

  // build the entry token and track the table fill
  always_comb begin
    count_nxt       = count_r;
    tok_entry       = '0;
    tok_entry.valid = in_valid;
    tok_entry.kind  = in_data.kind;
    tok_entry.cnt   = count_r;
    case (in_data.kind)
      KIND_APPEND: begin
        tok_entry.a = in_data.entry_network;
        tok_entry.b = in_data.entry_gateway;
        tok_entry.c = in_data.entry_mask;
        if (count_r >= COUNT_FULL) begin
          tok_entry.status = 1'b1;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_LOOKUP: begin
        tok_entry.a = in_data.lookup_address;
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        tok_entry.cnt = '0;
      end
    endcase
  end

  assign tok_c[0] = tok_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc) begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_cell
    nhpm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .tok_in   (tok_c[i]),
      .tok_out  (tok_c[i+1]),
      .rdy_out  (rdy[i+1]),
      .rdy_in   (rdy[i])
    );
  end

  assign rdy[ROUTE_ENTRIES] = !out_valid_r || !out_stall;
  assign tok_last           = tok_c[ROUTE_ENTRIES];

  always_comb begin
    out_data_nxt.status   = tok_last.status;
    out_data_nxt.next_hop = '0;
    if (tok_last.kind == KIND_LOOKUP) begin
      // zero gateway means directly attached: hand back the address
      out_data_nxt.next_hop = (tok_last.b != '0) ? tok_last.b : tok_last.a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[ROUTE_ENTRIES]) begin
      out_valid_r <= tok_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ROUTE_ENTRIES]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("route count beyond table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.kind == KIND_CLEAR) |=> count_r == '0)
    else $error("clear did not empty the table");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.kind == KIND_APPEND) && (count_r == COUNT_FULL)
    |=> count_r == COUNT_FULL)
    else $error("rejected append changed the count");

  a_reject_no_hop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status |-> out_data_r.next_hop == '0)
    else $error("rejected append carries a next hop");

endmodule

### design/nhpm_cell.sv
// One route cell: holds a single table entry and one in-flight token.
module nhpm_cell import nhpm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  tok_t             tok_in,
  output tok_t             tok_out,
  input  logic             rdy_out,
  output logic             rdy_in
);

  tok_t        tok_r;
  tok_t        tok_nxt;
  logic [31:0] net_r;
  logic [31:0] gw_r;
  logic [31:0] mask_r;
  logic        entry_used;
  logic        entry_hit;
  logic        wr_en;

  assign rdy_in  = !tok_r.valid || rdy_out;
  assign tok_out = tok_r;

  always_comb begin
    tok_nxt    = tok_in;
    entry_used = tok_in.cnt > CNT_W'(cell_idx);
    // later entries win ties, hence >=
    entry_hit  = entry_used && ((net_r & mask_r) == (tok_in.a & mask_r)) &&
                 (mask_r >= tok_in.c);
    if (tok_in.valid && (tok_in.kind == KIND_LOOKUP) && entry_hit) begin
      tok_nxt.b = gw_r;
      tok_nxt.c = mask_r;
    end
    wr_en = rdy_in && tok_in.valid && (tok_in.kind == KIND_APPEND) &&
            !tok_in.status && (tok_in.cnt == CNT_W'(cell_idx));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (rdy_in) begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      net_r  <= tok_in.a;
      gw_r   <= tok_in.b;
      mask_r <= tok_in.c;
    end
  end

endmodule
